// ----- rtl/ppc_pkg.sv -----
// ppc_pkg: shared types and constants for the polygon plane clipper.
// No dependencies.
package ppc_pkg;

   localparam int CoordWidth = 32;
   localparam int MaskBits   = 8;
   localparam int DistWidth  = 64;
   localparam int FracWidth  = 32;

   typedef struct packed {
      logic [MaskBits-1:0]          mask;
      logic signed [CoordWidth-1:0] z;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] x;
   } vertex_type;

   // one edge job from the front end to the back end
   typedef struct packed {
      vertex_type                  v0;
      logic signed [DistWidth-1:0] d0;
      vertex_type                  v1;
      logic signed [DistWidth-1:0] d1;
      logic                        do_edge;
      logic                        close_edge;
      logic                        last;
   } edge_job_type;

   localparam int QueueDepth = 4;
   localparam int QueueIdxW  = 2;

   localparam logic [2:0] CsrPlaneA   = 3'd0;
   localparam logic [2:0] CsrPlaneB   = 3'd1;
   localparam logic [2:0] CsrPlaneC   = 3'd2;
   localparam logic [2:0] CsrOffset   = 3'd3;
   localparam logic [2:0] CsrPlaneBit = 3'd4;

endpackage

// ----- rtl/polygon_plane_clipper_unit.sv -----
// Clips a convex polygon, streamed one vertex per transfer with tlast on the
// final vertex, against one plane a*x+b*y+c*z+d (Q16.16). Each vertex passes
// through the front end (three shared 32x32 multiplies and a saturate); each
// crossing edge in the back end runs the bit-serial 32-step divider (skipped if
// the ratio is one) plus three interpolation multiplies; each emitted vertex goes
// through the output register. A 4-entry job queue lets the front end run ahead.
// Write the plane registers only while idle.
module polygon_plane_clipper_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // in_x, in_y, in_z, in_mask
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // out_x, out_y, out_z, out_mask
   output logic         rsp_tlast,
   output logic         rsp_tuser,  // out_empty
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic signed [31:0] plane_a_ff, plane_b_ff, plane_c_ff, plane_offset_ff;
   logic [7:0]         plane_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff      <= '0;
         plane_b_ff      <= '0;
         plane_c_ff      <= '0;
         plane_offset_ff <= '0;
         plane_bit_ff    <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            ppc_pkg::CsrPlaneA:   plane_a_ff      <= csr_wdata;
            ppc_pkg::CsrPlaneB:   plane_b_ff      <= csr_wdata;
            ppc_pkg::CsrPlaneC:   plane_c_ff      <= csr_wdata;
            ppc_pkg::CsrOffset:   plane_offset_ff <= csr_wdata;
            ppc_pkg::CsrPlaneBit: plane_bit_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ppc_pkg::vertex_type   in_vtx, out_vtx;
   ppc_pkg::edge_job_type f_job, q_job;
   logic                  f_valid, f_ready, q_valid, q_ready;

   assign in_vtx.x    = req_tdata[31:0];
   assign in_vtx.y    = req_tdata[63:32];
   assign in_vtx.z    = req_tdata[95:64];
   assign in_vtx.mask = req_tdata[103:96];

   ppc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_vtx, .in_last(req_tlast),
      .plane_a(plane_a_ff), .plane_b(plane_b_ff), .plane_c(plane_c_ff),
      .plane_offset(plane_offset_ff),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   ppc_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
   );

   ppc_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .plane_bit(plane_bit_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_vtx,
      .out_last(rsp_tlast), .out_empty(rsp_tuser)
   );

   assign rsp_tdata = {out_vtx.mask, out_vtx.z, out_vtx.y, out_vtx.x};

endmodule

// ----- rtl/ppc_front.sv -----
// ppc_front: takes vertices, computes the plane distance and pushes edge jobs.
// Depends on ppc_pkg.
module ppc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ppc_pkg::vertex_type       in_vtx,
   input  logic                      in_last,
   input  logic signed [31:0]        plane_a,
   input  logic signed [31:0]        plane_b,
   input  logic signed [31:0]        plane_c,
   input  logic signed [31:0]        plane_offset,
   output logic                      job_valid,
   input  logic                      job_ready,
   output ppc_pkg::edge_job_type     job
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_X, S_MUL_Y, S_MUL_Z, S_SAT, S_EDGE, S_CLOSE
   } state_type;

   state_type           state_ff, state_in;
   ppc_pkg::vertex_type cur_ff, cur_in;
   logic                last_ff, last_in;
   logic signed [65:0]  acc_ff, acc_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [63:0]  d_ff, d_in;
   ppc_pkg::vertex_type first_ff, first_in, prev_ff, prev_in;
   logic signed [63:0]  first_d_ff, first_d_in, prev_d_ff, prev_d_in;
   logic                have_first_ff, have_first_in;

   logic signed [31:0]  mul_a, mul_b;

   always_comb begin
      mul_a = plane_a;
      mul_b = cur_ff.x;
      unique case (state_ff)
         S_MUL_Y: begin mul_a = plane_b; mul_b = cur_ff.y; end
         S_MUL_Z: begin mul_a = plane_c; mul_b = cur_ff.z; end
         default: begin mul_a = plane_a; mul_b = cur_ff.x; end
      endcase
   end

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      prod_in       = mul_a * mul_b;
      d_in          = d_ff;
      first_in      = first_ff;
      first_d_in    = first_d_ff;
      prev_in       = prev_ff;
      prev_d_in     = prev_d_ff;
      have_first_in = have_first_ff;
      job_valid     = 1'b0;
      job           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cur_in   = in_vtx;
               last_in  = in_last;
               acc_in   = 66'(plane_offset) <<< 16;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: state_in = S_MUL_Y;
         S_MUL_Y: begin
            acc_in   = acc_ff + 66'(prod_ff);
            state_in = S_MUL_Z;
         end
         S_MUL_Z: begin
            acc_in   = acc_ff + 66'(prod_ff);
            state_in = S_SAT;
         end
         S_SAT: begin
            acc_in = acc_ff + 66'(prod_ff);
            if (acc_in > 66'sh0_7FFF_FFFF_FFFF_FFFF)
               d_in = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (acc_in < -66'sh0_8000_0000_0000_0000)
               d_in = 64'sh8000_0000_0000_0000;
            else
               d_in = acc_in[63:0];
            state_in = S_EDGE;
         end
         S_EDGE: begin
            job_valid      = 1'b1;
            job.v0         = prev_ff;
            job.d0         = prev_d_ff;
            job.v1         = cur_ff;
            job.d1         = d_ff;
            job.do_edge    = have_first_ff;
            job.close_edge = 1'b0;
            job.last       = 1'b0;
            if (job_ready) begin
               if (!have_first_ff) begin
                  first_in   = cur_ff;
                  first_d_in = d_ff;
               end
               have_first_in = 1'b1;
               prev_in       = cur_ff;
               prev_d_in     = d_ff;
               state_in      = last_ff ? S_CLOSE : S_IDLE;
            end
         end
         S_CLOSE: begin
            job_valid      = 1'b1;
            job.v0         = cur_ff;
            job.d0         = d_ff;
            job.v1         = first_ff;
            job.d1         = first_d_ff;
            job.do_edge    = 1'b1;
            job.close_edge = 1'b1;
            job.last       = 1'b1;
            if (job_ready) begin
               have_first_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_first_ff <= 1'b0;
         first_ff      <= '0;
         first_d_ff    <= '0;
         prev_ff       <= '0;
         prev_d_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         have_first_ff <= have_first_in;
         first_ff      <= first_in;
         first_d_ff    <= first_d_in;
         prev_ff       <= prev_in;
         prev_d_ff     <= prev_d_in;
      end
      cur_ff  <= cur_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      d_ff    <= d_in;
   end

endmodule

// ----- rtl/ppc_queue.sv -----
// ppc_queue: small FIFO of edge jobs between front and back end.
// Depends on ppc_pkg.
module ppc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  ppc_pkg::edge_job_type wr_data,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output ppc_pkg::edge_job_type rd_data
);

   ppc_pkg::edge_job_type           mem_ff [ppc_pkg::QueueDepth];
   logic [ppc_pkg::QueueIdxW-1:0]   wptr_ff, rptr_ff;
   logic [ppc_pkg::QueueIdxW:0]     count_ff;
   logic                            push, pop;

   assign wr_ready = (count_ff != 3'(ppc_pkg::QueueDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop) rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_ff + {2'b0, push} - {2'b0, pop};
      end
      if (push) mem_ff[wptr_ff] <= wr_data;
   end

endmodule

// ----- rtl/ppc_back.sv -----
// ppc_back: runs edge jobs: passes inside vertices, divides for the crossing
// ratio, interpolates, and holds one vertex back to tag the last. Uses ppc_pkg.
module ppc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  ppc_pkg::edge_job_type job,
   input  logic [7:0]            plane_bit,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ppc_pkg::vertex_type   out_vtx,
   output logic                  out_last,
   output logic                  out_empty
);

   typedef enum logic [3:0] {
      S_IDLE, S_PASS, S_DIV_INIT, S_DIV, S_LERP_X, S_LERP_Y, S_LERP_Z,
      S_LERP_END, S_PUSH, S_FINAL, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   ppc_pkg::edge_job_type job_ff, job_in;
   logic [63:0]         rem_ff, rem_in, den_ff, den_in;
   logic [32:0]         r_ff, r_in;
   logic [5:0]          cnt_ff, cnt_in;
   ppc_pkg::vertex_type cand_ff, cand_in;
   ppc_pkg::vertex_type held_ff, held_in;
   logic                any_ff, any_in;
   logic                ret_ff, ret_in;   // back to this after a push
   ppc_pkg::vertex_type ov_ff, ov_in;
   logic                ol_ff, ol_in, oe_ff, oe_in, ovld_ff, ovld_in;
   logic [1:0]          lane_ff, lane_in;
   logic [63:0]         prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic signed [31:0]  pc1_ff, pc1_in;

   logic [63:0] mag0, mag1, rem_sh;
   logic        carry;
   logic signed [32:0] diff;
   logic [31:0] dmag;
   logic signed [31:0] c0, c1;
   logic [31:0] t;
   logic signed [31:0] lres_prev;

   assign mag0 = job_ff.d0[63] ? 64'(-job_ff.d0) : 64'(job_ff.d0);
   assign mag1 = job_ff.d1[63] ? 64'(-job_ff.d1) : 64'(job_ff.d1);
   assign carry  = rem_ff[63];
   assign rem_sh = {rem_ff[62:0], 1'b0};

   always_comb begin
      unique case (lane_ff)
         2'd1:    begin c0 = job_ff.v0.y; c1 = job_ff.v1.y; end
         2'd2:    begin c0 = job_ff.v0.z; c1 = job_ff.v1.z; end
         default: begin c0 = job_ff.v0.x; c1 = job_ff.v1.x; end
      endcase
   end
   assign diff = 33'(c0) - 33'(c1);
   assign dmag = diff[32] ? 32'(-diff) : diff[31:0];
   // rounded product and coordinate of the lane registered in the previous state
   assign t         = 32'((prod_ff + 64'h8000_0000) >> 32);
   assign lres_prev = neg_ff ? pc1_ff - $signed(t) : pc1_ff + $signed(t);

   assign job_ready = (state_ff == S_IDLE) && !ovld_ff;
   assign out_valid = ovld_ff;
   assign out_vtx   = ov_ff;
   assign out_last  = ol_ff;
   assign out_empty = oe_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      cand_in  = cand_ff;
      held_in  = held_ff;
      any_in   = any_ff;
      ret_in   = ret_ff;
      ov_in    = ov_ff;
      ol_in    = ol_ff;
      oe_in    = oe_ff;
      ovld_in  = ovld_ff && !out_ready;
      lane_in  = lane_ff;
      prod_in  = 64'(dmag) * 64'(r_ff[31:0]);
      neg_in   = diff[32];
      pc1_in   = c1;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && !ovld_ff) begin
               job_in   = job;
               state_in = !job.do_edge ? (job.last ? S_FINAL : S_IDLE) :
                          (!job.d0[63] ? S_PASS : S_DIV_INIT);
               if (job.do_edge && job.d0[63] && !(job.d1 > 0))
                  state_in = job.last ? S_FINAL : S_IDLE;
            end
         end
         S_PASS: begin
            cand_in  = job_ff.v0;
            ret_in   = job_ff.d1[63];   // crossing follows
            state_in = S_PUSH;
         end
         S_DIV_INIT: begin
            den_in = mag0 + mag1;
            rem_in = mag1;
            r_in   = '0;
            cnt_in = '0;
            if (mag1 >= mag0 + mag1) begin
               r_in     = 33'h1_0000_0000;
               lane_in  = 2'd0;
               state_in = S_LERP_X;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = rem_sh;
            r_in   = {r_ff[31:0], 1'b0};
            if (carry || rem_sh >= den_ff) begin
               rem_in = rem_sh - den_ff;
               r_in[0] = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               lane_in  = 2'd0;
               state_in = S_LERP_X;
            end
         end
         // product of a lane is registered, its coordinate lands in the next state
         S_LERP_X: begin
            lane_in  = lane_ff + 2'd1;
            state_in = S_LERP_Y;
         end
         S_LERP_Y: begin
            cand_in.x = r_ff[32] ? job_ff.v0.x : lres_prev;
            lane_in   = lane_ff + 2'd1;
            state_in  = S_LERP_Z;
         end
         S_LERP_Z: begin
            cand_in.y = r_ff[32] ? job_ff.v0.y : lres_prev;
            lane_in   = lane_ff + 2'd1;
            state_in  = S_LERP_END;
         end
         S_LERP_END: begin
            cand_in.z    = r_ff[32] ? job_ff.v0.z : lres_prev;
            cand_in.mask = (job_ff.v0.mask & job_ff.v1.mask) | plane_bit;
            ret_in   = 1'b0;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            held_in = cand_ff;
            any_in  = 1'b1;
            if (any_ff) begin
               ov_in   = held_ff;
               ol_in   = 1'b0;
               oe_in   = 1'b0;
               ovld_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = ret_ff ? S_DIV_INIT : (job_ff.last ? S_FINAL : S_IDLE);
            end
         end
         S_OUT: begin
            if (!ovld_ff)
               state_in = ret_ff ? S_DIV_INIT : (job_ff.last ? S_FINAL : S_IDLE);
         end
         S_FINAL: begin
            if (!ovld_ff) begin
               ov_in   = any_ff ? held_ff : '0;
               ol_in   = 1'b1;
               oe_in   = !any_ff;
               ovld_in = 1'b1;
               any_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         any_ff   <= 1'b0;
         ovld_ff  <= 1'b0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         any_ff   <= any_in;
         ovld_ff  <= ovld_in;
         held_ff  <= held_in;
      end
      job_ff  <= job_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
      ret_ff  <= ret_in;
      ov_ff   <= ov_in;
      ol_ff   <= ol_in;
      oe_ff   <= oe_in;
      lane_ff <= lane_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      pc1_ff  <= pc1_in;
      cand_ff <= cand_in;
   end

endmodule

// ----- sim/polygon_plane_clipper_checker.sv -----
// Checker for polygon_plane_clipper_unit: watches the vertex input and result streams,
// predicts the clipped vertices for each accepted transfer and compares them in order.
// Depends on ppc_pkg for the CSR indexes.
`timescale 1ns / 100ps
module polygon_plane_clipper_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           result_count,
   output int           empty_count,
   output int           cross_count
);

   typedef struct {
      longint x, y, z;
      logic [7:0] mask;
   } point_type;

   typedef struct {
      logic [103:0] data;
      logic         last;
      logic         empty;
   } clip_result_type;

   clip_result_type clipped_q[$];

   longint coef_a, coef_b, coef_c, coef_d;
   logic [7:0] clip_bit;
   point_type first_pt, prev_pt, held_pt;
   longint first_dist, prev_dist;
   bit     have_first, any_out;

   // exact plane distance in Q32.32, saturated to 64 bits
   function automatic longint plane_distance(point_type p);
      logic signed [127:0] s;
      s = 128'(signed'(coef_a)) * 128'(signed'(p.x)) + 128'(signed'(coef_b)) * 128'(signed'(p.y))
        + 128'(signed'(coef_c)) * 128'(signed'(p.z)) + 128'(signed'(coef_d)) * 128'sd65536;
      if (s > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s);
   endfunction

   function automatic longint blend(longint a0, longint a1, logic [32:0] r);
      longint diff;
      logic [63:0] m, t;
      logic [95:0] prod;
      if (r[32]) return a0;
      diff = a0 - a1;
      m = diff < 0 ? -diff : diff;
      prod = 96'(m) * 96'(r) + 96'h8000_0000;
      t = prod[95:32];
      return diff < 0 ? a1 - longint'(t) : a1 + longint'(t);
   endfunction

   function automatic void queue_point(point_type p, bit last, bit empty);
      clip_result_type e;
      e.data = {p.mask, p.z[31:0], p.y[31:0], p.x[31:0]};
      e.last = last;
      e.empty = empty;
      clipped_q.insert(clipped_q.size(), e);
   endfunction

   function automatic void emit(point_type p);
      if (any_out) queue_point(held_pt, 0, 0);
      held_pt = p;
      any_out = 1;
   endfunction

   function automatic void emit_crossing(point_type v0, longint d0, point_type v1, longint d1);
      logic [64:0] num, den, rem;
      logic [32:0] r;
      point_type p;
      num = d1 < 0 ? -65'(signed'(d1)) : 65'(d1);
      den = num + (d0 < 0 ? -65'(signed'(d0)) : 65'(d0));
      if (num >= den) r = 33'h1_0000_0000;
      else begin
         r = 0;
         rem = num;
         for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            r = r << 1;
            if (rem >= den) begin
               rem = rem - den;
               r[0] = 1'b1;
            end
         end
      end
      p.x = blend(v0.x, v1.x, r);
      p.y = blend(v0.y, v1.y, r);
      p.z = blend(v0.z, v1.z, r);
      p.mask = (v0.mask & v1.mask) | clip_bit;
      cross_count++;
      emit(p);
   endfunction

   function automatic void clip_edge(point_type v0, longint d0, point_type v1, longint d1);
      if (d0 >= 0) begin
         emit(v0);
         if (d1 < 0) emit_crossing(v0, d0, v1, d1);
      end else if (d1 > 0) begin
         emit_crossing(v0, d0, v1, d1);
      end
   endfunction

   function automatic void clip_vertex(logic [103:0] data, bit last);
      point_type v, zero_pt;
      longint d;
      v.x = longint'(signed'(data[31:0]));
      v.y = longint'(signed'(data[63:32]));
      v.z = longint'(signed'(data[95:64]));
      v.mask = data[103:96];
      d = plane_distance(v);
      if (!have_first) begin
         first_pt = v;
         first_dist = d;
         have_first = 1;
      end else begin
         clip_edge(prev_pt, prev_dist, v, d);
      end
      prev_pt = v;
      prev_dist = d;
      if (last) begin
         clip_edge(v, d, first_pt, first_dist);
         if (any_out) queue_point(held_pt, 1, 0);
         else begin
            zero_pt = '{0, 0, 0, 8'h00};
            queue_point(zero_pt, 1, 1);
            empty_count++;
         end
         have_first = 0;
         any_out = 0;
      end
   endfunction

   always @(posedge clock) begin
      clip_result_type e;
      if (reset) begin
         coef_a = 0; coef_b = 0; coef_c = 0; coef_d = 0;
         clip_bit = 8'h01;
         have_first = 0;
         any_out = 0;
         fail_count = 0;
         result_count = 0;
         empty_count = 0;
         cross_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ppc_pkg::CsrPlaneA:   coef_a = longint'(signed'(csr_wdata));
               ppc_pkg::CsrPlaneB:   coef_b = longint'(signed'(csr_wdata));
               ppc_pkg::CsrPlaneC:   coef_c = longint'(signed'(csr_wdata));
               ppc_pkg::CsrOffset:   coef_d = longint'(signed'(csr_wdata));
               ppc_pkg::CsrPlaneBit: clip_bit = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) clip_vertex(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (clipped_q.size() == 0) begin
               $error("unexpected result transfer: data %h last %b empty %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               e = clipped_q.pop_front();
               if (rsp_tdata[31:0] !== e.data[31:0]) begin
                  $error("out_x: expected %h, got %h", e.data[31:0], rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== e.data[63:32]) begin
                  $error("out_y: expected %h, got %h", e.data[63:32], rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tdata[95:64] !== e.data[95:64]) begin
                  $error("out_z: expected %h, got %h", e.data[95:64], rsp_tdata[95:64]);
                  fail_count++;
               end
               if (rsp_tdata[103:96] !== e.data[103:96]) begin
                  $error("out_mask: expected %h, got %h", e.data[103:96], rsp_tdata[103:96]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("out_last: expected %b, got %b", e.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== e.empty) begin
                  $error("out_empty: expected %b, got %b", e.empty, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
      pending_count = clipped_q.size();
   end

endmodule

// ----- sim/polygon_plane_clipper_unit_tb.sv -----
// Testbench top for polygon_plane_clipper_unit: drives polygons and plane settings,
// randomizes idling on both streams and reports the verdict. Depends on ppc_pkg and
// polygon_plane_clipper_checker.
`timescale 1ns / 100ps
module polygon_plane_clipper_unit_tb;

   localparam int StallLimit = 20000;
   localparam int DrainCycles = 300;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tlast;
   logic [103:0] req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast, rsp_tuser;
   logic [103:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;
   int           fail_count, pending_count, result_count, empty_count, cross_count;
   int           vertex_count, idle_cycles;
   bit           hold_rsp;

   polygon_plane_clipper_unit i_dut (.*);

   polygon_plane_clipper_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold while the sender keeps pushing
   initial begin
      int wait_n;
      bit long_hold_done;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp && !long_hold_done) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 400; i++) @(posedge clock);
            long_hold_done = 1;
         end
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [7:0] pbit);
      write_csr(ppc_pkg::CsrPlaneA, a);
      write_csr(ppc_pkg::CsrPlaneB, b);
      write_csr(ppc_pkg::CsrPlaneC, c);
      write_csr(ppc_pkg::CsrOffset, d);
      write_csr(ppc_pkg::CsrPlaneBit, {24'h0, pbit});
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [7:0] mask, bit last, bit no_gap);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {mask, z, y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      vertex_count++;
   endtask

   function automatic logic [31:0] rand_coord(int style);
      case (style)
         0: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_polygon(int n, int style, bit no_gap);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(style), rand_coord(style), rand_coord(style),
                     8'($urandom), i == n - 1, no_gap);
      req_tvalid <= 1'b0;
   endtask

   initial begin
      req_tvalid = 1'b0; req_tlast = 1'b0; req_tdata = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      vertex_count = 0; hold_rsp = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset plane: distance zero everywhere, everything passes
      send_vertex(32'h0001_0000, 32'h0, 32'h0, 8'h00, 1, 0);
      req_tvalid <= 1'b0;
      wait_drained();

      // plane x >= 0
      set_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0, 8'h04);
      // straddling triangle
      send_vertex(32'hFFFF_0000, 32'h0, 32'h0, 8'hFF, 0, 0);
      send_vertex(32'h0003_0000, 32'h0001_0000, 32'h0, 8'h0F, 0, 0);
      send_vertex(32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 8'hF0, 1, 0);
      // fully outside: empty
      send_vertex(32'hFFFF_0000, 32'h0, 32'h0, 8'h01, 0, 0);
      send_vertex(32'hFFFE_0000, 32'h0005_0000, 32'h0, 8'h02, 1, 0);
      // single vertex inside and outside
      send_vertex(32'h0000_0000, 32'h1234_5678, 32'h0, 8'h80, 1, 0);
      send_vertex(32'h8000_0000, 32'h0, 32'h0, 8'h00, 1, 0);
      // vertex exactly on plane next to negative vertex
      send_vertex(32'h0, 32'h0001_0000, 32'h0, 8'h01, 0, 0);
      send_vertex(32'hFFFE_0000, 32'h0, 32'h0, 8'h03, 0, 0);
      send_vertex(32'h0002_0000, 32'h0, 32'hFFFF_FFFF, 8'h03, 1, 0);
      // coordinate extremes
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF, 0, 0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1, 0);
      req_tvalid <= 1'b0;
      wait_drained();

      set_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
      send_polygon(4, 1, 0);
      send_polygon(3, 2, 0);
      wait_drained();
      set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00);
      send_polygon(4, 1, 0);
      send_polygon(3, 2, 0);
      wait_drained();

      // random phases with random plane settings
      for (int phase = 0; phase < 6; phase++) begin
         set_plane(phase % 2 ? $urandom : {16'($urandom_range(0, 4) - 2), 16'h0},
                   phase % 2 ? $urandom : {16'($urandom_range(0, 4) - 2), 16'h0},
                   phase % 2 ? $urandom : {16'($urandom_range(0, 4) - 2), 16'h0},
                   $urandom, 8'($urandom));
         if (phase == 2) hold_rsp = 1;
         while (vertex_count < 40 + (phase + 1) * 55) begin
            int n;
            n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 7);
            send_polygon(n, $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2),
                         phase == 2);
         end
         // pause until everything is out
         wait_drained();
      end

      $display("Ran %0d vertices, %0d results, %0d crossings, %0d empty polygons.",
               vertex_count, result_count, cross_count, empty_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
